FILE: hdl/indexed_list_engine_assert.svh
// Assertion macros for the indexed list engine checker.
// Needs nothing else; included by files that hold concurrent assertions.
`ifndef INDEXED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_ASSERT_SVH

// Property that is switched off while reset is high.
`define ILE_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("indexed_list_engine assertion failed");

// Property that is also checked while reset is high.
`define ILE_ASSERT_RST(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("indexed_list_engine assertion failed");

`endif

FILE: hdl/ile_pkg.sv
// Shared types and constants for the indexed list engine.
// No dependencies; imported by the cell, the top level and the checker.
package ile_pkg;

  localparam int DEPTH   = 64;
  localparam int DATA_W  = 32;
  localparam int WORD_W  = 32;
  localparam int POS_W   = 7;
  localparam int MODE_W  = 3;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int IN_W    = 48;
  localparam int OUT_W   = 48;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_POP    = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_GET    = 3'd4,
    MODE_SET    = 3'd5,
    MODE_CLEAR  = 3'd6
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_REMOVE = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t          cmd;
    logic [CMP_W-1:0]   target;
    logic [DATA_W-1:0]  word;
  } cell_ctrl_t;

endpackage

FILE: hdl/ile_cell.sv
// One storage cell of the list: holds a word and shifts with its neighbors.
// Depends on ile_pkg for the control struct and widths.
module ile_cell
  import ile_pkg::*;
(
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [CMP_W-1:0]  idx,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data
);

  logic hit;
  logic above;

  assign hit   = (ctrl.target == idx);
  assign above = (idx > ctrl.target);

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      CMD_WRITE: begin
        if (hit) data <= ctrl.word;
      end
      CMD_INSERT: begin
        if (hit) data <= ctrl.word;
        else if (above) data <= left_data;
      end
      CMD_REMOVE: begin
        if (hit || above) data <= right_data;
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/indexed_list_engine.sv
// Each result is registered and appears on the master side in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; s_tready = !m_tvalid || m_tready.
// Insert and remove shift every cell at once, so they are no slower than the other operations.
// Reset clears the list length and the output valid; stored words are not cleared.
// Top level of the indexed list engine; uses ile_pkg and a row of ile_cell instances.
module indexed_list_engine
  import ile_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // mode[2:0], position[9:3], word_in[41:10], zeros
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // status[1:0], word_out[33:2], count[40:34], zeros
);

  logic [MODE_W-1:0] mode_bits;
  logic [POS_W-1:0]  position;
  logic [WORD_W-1:0] word_in;
  logic              accept;
  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  used_x;
  logic              full;

  logic [CNT_W-1:0]  used;
  logic [CNT_W-1:0]  used_next;
  status_t           stat_next;
  logic              rd_en;
  cell_cmd_t         cmd;
  logic [CMP_W-1:0]  target;
  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] rd_word;

  status_t           out_status;
  logic [WORD_W-1:0] out_word;
  logic [POS_W-1:0]  out_count;

  logic [DATA_W-1:0] cell_data [DEPTH];

  assign mode_bits = s_tdata[2:0];
  assign position  = s_tdata[9:3];
  assign word_in   = s_tdata[41:10];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign pos_x    = CMP_W'(position);
  assign used_x   = CMP_W'(used);
  assign full     = (used_x == CMP_W'(DEPTH));

  always_comb begin
    used_next = used;
    stat_next = ST_OK;
    rd_en     = 1'b0;
    cmd       = CMD_NONE;
    target    = pos_x;
    unique case (mode_t'(mode_bits))
      MODE_APPEND: begin
        if (full) stat_next = ST_FULL;
        else begin
          cmd       = CMD_WRITE;
          target    = used_x;
          used_next = used + 1'b1;
        end
      end
      MODE_INSERT: begin
        if (pos_x > used_x) stat_next = ST_RANGE;
        else if (full) stat_next = ST_FULL;
        else begin
          cmd       = (pos_x == used_x) ? CMD_WRITE : CMD_INSERT;
          used_next = used + 1'b1;
        end
      end
      MODE_POP: begin
        if (used == '0) stat_next = ST_EMPTY;
        else used_next = used - 1'b1;
      end
      MODE_REMOVE: begin
        if (pos_x >= used_x) stat_next = ST_RANGE;
        else begin
          cmd       = CMD_REMOVE;
          used_next = used - 1'b1;
        end
      end
      MODE_GET: begin
        if (pos_x >= used_x) stat_next = ST_RANGE;
        else rd_en = 1'b1;
      end
      MODE_SET: begin
        if (pos_x >= used_x) stat_next = ST_RANGE;
        else cmd = CMD_WRITE;
      end
      MODE_CLEAR: begin
        used_next = '0;
      end
      default: ;
    endcase
  end

  assign ctrl.cmd    = accept ? cmd : CMD_NONE;
  assign ctrl.target = target;
  assign ctrl.word   = DATA_W'(word_in);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_data;
    logic [DATA_W-1:0] right_data;
    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_left
      assign left_data = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_right
      assign right_data = cell_data[i+1];
    end
    ile_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (CMP_W'(i)),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (pos_x == CMP_W'(k)) rd_word = rd_word | cell_data[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        used     <= used_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= stat_next;
      out_word   <= rd_en ? WORD_W'(rd_word) : '0;
      out_count  <= POS_W'(used_next);
    end
  end

  assign m_tdata = {(OUT_W - STAT_W - WORD_W - POS_W)'(0), out_count, out_word, out_status};

endmodule

FILE: hdl/ile_checker.sv
// Port-level checks for indexed_list_engine, attached by the bind below.
// Depends on ile_pkg and the macros in indexed_list_engine_assert.svh.
`include "indexed_list_engine_assert.svh"

module ile_checker
  import ile_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  `ILE_ASSERT_RST(a_reset_clears_out, clk, rst |=> !m_tvalid)
  `ILE_ASSERT(a_count_bound, clk, rst, m_tvalid |-> (m_tdata[40:34] <= POS_W'(DEPTH)))
  `ILE_ASSERT(a_fail_no_word, clk, rst, (m_tvalid && m_tdata[1:0] != ST_OK) |-> (m_tdata[33:2] == '0))
  `ILE_ASSERT(a_word_needs_entries, clk, rst, (m_tvalid && m_tdata[33:2] != '0) |-> (m_tdata[40:34] != '0))
  `ILE_ASSERT(a_stall_holds, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

endmodule

bind indexed_list_engine ile_checker u_ile_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: sim/tb_top.sv
// Self-checking testbench for indexed_list_engine: directed and random list operations.
// Keeps its own copy of the list to predict each result; depends on ile_pkg and the RTL.
module tb_top;
  import ile_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;
  localparam int IDLE_PCT = 27;
  localparam int CALM_FIRST = 600;
  localparam int CALM_LAST = 1100;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1480;
  localparam int BIAS_GROW = 0;
  localparam int BIAS_SHRINK = 1;
  localparam int BIAS_MIXED = 2;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] word_in;
  } list_op_t;

  typedef struct {
    status_t           status;
    logic [WORD_W-1:0] word_out;
    logic [CNT_W-1:0]  count;
  } list_result_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;

  list_op_t     pending_ops[$];
  list_result_t expected_results[$];
  logic [WORD_W-1:0] list_words [DEPTH];
  int list_len;
  int shadow_len;
  int total_items;
  int accepted_items;
  int fail_count;
  int cycle_no;
  int stall_cycles;
  bit op_taken;

  indexed_list_engine DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  function automatic list_result_t predict_list_op(input list_op_t op);
    list_result_t res;
    int pos;
    pos = int'(op.position);
    res.status = ST_OK;
    res.word_out = '0;
    case (op.mode)
      MODE_APPEND: begin
        if (list_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          list_words[list_len] = op.word_in;
          list_len++;
        end
      end
      MODE_INSERT: begin
        if (pos > list_len) begin
          res.status = ST_RANGE;
        end else if (list_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = op.word_in;
          list_len++;
        end
      end
      MODE_POP: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else list_len--;
      end
      MODE_REMOVE: begin
        if (pos >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      MODE_GET: begin
        if (pos >= list_len) res.status = ST_RANGE;
        else res.word_out = list_words[pos];
      end
      MODE_SET: begin
        if (pos >= list_len) res.status = ST_RANGE;
        else list_words[pos] = op.word_in;
      end
      MODE_CLEAR: begin
        list_len = 0;
      end
      default: ;
    endcase
    res.count = CNT_W'(list_len);
    return res;
  endfunction

  // Follows only the list length so that generated positions land mostly in range.
  function automatic void track_length(input list_op_t op);
    int pos;
    pos = int'(op.position);
    case (op.mode)
      MODE_APPEND: if (shadow_len < DEPTH) shadow_len++;
      MODE_INSERT: if (pos <= shadow_len && shadow_len < DEPTH) shadow_len++;
      MODE_POP:    if (shadow_len > 0) shadow_len--;
      MODE_REMOVE: if (pos < shadow_len) shadow_len--;
      MODE_CLEAR:  shadow_len = 0;
      default: ;
    endcase
  endfunction

  function automatic void queue_op(input logic [MODE_W-1:0] mode, input int pos,
                                   input logic [WORD_W-1:0] word);
    list_op_t op;
    op.mode = mode;
    op.position = POS_W'(pos);
    op.word_in = word;
    track_length(op);
    pending_ops.push_back(op);
  endfunction

  function automatic void queue_random_op(input int bias);
    logic [MODE_W-1:0] mode_order [8];
    int limits [8];
    int r;
    int pos;
    logic [WORD_W-1:0] word;
    mode_order = '{MODE_APPEND, MODE_INSERT, MODE_GET, MODE_SET,
                   MODE_REMOVE, MODE_POP, MODE_SPARE, MODE_CLEAR};
    case (bias)
      BIAS_GROW:   limits = '{35, 70, 80, 88, 94, 98, 99, 100};
      BIAS_SHRINK: limits = '{10, 20, 35, 45, 75, 95, 97, 100};
      default:     limits = '{20, 40, 55, 70, 82, 92, 95, 100};
    endcase
    r = $urandom_range(99);
    word = $urandom;
    case ($urandom_range(9))
      0: word = '0;
      1: word = '1;
      default: ;
    endcase
    if ($urandom_range(99) < 15) pos = $urandom_range(127);
    else if (mode_order[0] == MODE_APPEND && r < limits[1] && r >= limits[0])
      pos = $urandom_range(shadow_len);
    else pos = (shadow_len > 0) ? $urandom_range(shadow_len - 1) : 0;
    for (int k = 0; k < 8; k++) begin
      if (r < limits[k]) begin
        queue_op(mode_order[k], pos, word);
        return;
      end
    end
  endfunction

  function automatic bit take_break();
    if (cycle_no >= CALM_FIRST && cycle_no < CALM_LAST) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    list_op_t op;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || op_taken) begin
        if (pending_ops.size() > 0 && !take_break()) begin
          op = pending_ops.pop_front();
          s_tdata <= {6'b0, op.word_in, op.position, op.mode};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= !take_break();
    end
  end

  always @(posedge clk) begin
    list_op_t op;
    list_result_t exp_res;
    status_t got_status;
    logic [WORD_W-1:0] got_word;
    logic [CNT_W-1:0] got_count;
    cycle_no <= cycle_no + 1;
    op_taken <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (m_tvalid && m_tready) begin
        got_status = status_t'(m_tdata[1:0]);
        got_word = m_tdata[33:2];
        got_count = m_tdata[40:34];
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d, word_out 0x%08h, count %0d",
                 got_status, got_word, got_count);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (got_status !== exp_res.status) begin
            $error("status: expected %0d, actual %0d", exp_res.status, got_status);
            fail_count++;
          end
          if (got_word !== exp_res.word_out) begin
            $error("word_out: expected 0x%08h, actual 0x%08h", exp_res.word_out, got_word);
            fail_count++;
          end
          if (got_count !== exp_res.count) begin
            $error("count: expected %0d, actual %0d", exp_res.count, got_count);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        op.mode = s_tdata[2:0];
        op.position = s_tdata[9:3];
        op.word_in = s_tdata[41:10];
        expected_results.push_back(predict_list_op(op));
        accepted_items++;
      end
    end
  end

  always @(posedge clk) begin
    if (stall_cycles >= STALL_LIMIT) begin
      $display("indexed_list_engine regression: fail");
      $finish;
    end
  end

  initial begin
    int bias;
    int run_len;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    op_taken = 1'b0;
    list_len = 0;
    shadow_len = 0;
    accepted_items = 0;
    fail_count = 0;
    cycle_no = 0;
    stall_cycles = 0;

    // Empty-list corner cases first, then shifting, range and clear checks.
    queue_op(MODE_POP, 0, 32'h0);
    queue_op(MODE_REMOVE, 0, 32'h0);
    queue_op(MODE_GET, 0, 32'h0);
    queue_op(MODE_SET, 0, 32'hFFFF_FFFF);
    queue_op(MODE_INSERT, 1, 32'h1111_1111);
    queue_op(MODE_INSERT, 0, 32'h0000_0000);
    queue_op(MODE_APPEND, 0, 32'hFFFF_FFFF);
    queue_op(MODE_INSERT, 0, 32'hA5A5_A5A5);
    queue_op(MODE_INSERT, 1, 32'h1234_5678);
    queue_op(MODE_GET, 0, 32'h0);
    queue_op(MODE_GET, 3, 32'h0);
    queue_op(MODE_GET, 4, 32'h0);
    queue_op(MODE_SET, 2, 32'h0);
    queue_op(MODE_REMOVE, 0, 32'h0);
    queue_op(MODE_REMOVE, 2, 32'h0);
    queue_op(MODE_GET, 127, 32'h0);
    queue_op(MODE_SPARE, 127, 32'hFFFF_FFFF);
    queue_op(MODE_POP, 0, 32'h0);
    queue_op(MODE_CLEAR, 0, 32'h0);
    queue_op(MODE_GET, 0, 32'h0);
    queue_op(MODE_APPEND, 0, 32'h8000_0001);
    queue_op(MODE_INSERT, 127, 32'hFFFF_FFFF);

    // A long growth run first so the full-list cases are reached early.
    for (int k = 0; k < 90; k++) queue_random_op(BIAS_GROW);
    while (pending_ops.size() < RANDOM_ITEMS) begin
      bias = $urandom_range(2);
      run_len = $urandom_range(20, 120);
      for (int k = 0; k < run_len; k++) queue_random_op(bias);
    end
    total_items = pending_ops.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (accepted_items == total_items);
    wait (expected_results.size() == 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("indexed_list_engine regression: pass");
    end else begin
      $display("indexed_list_engine regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/ile_pkg.sv
hdl/ile_cell.sv
hdl/indexed_list_engine.sv
hdl/ile_checker.sv
sim/tb_top.sv
